/* rtl/ils_pkg.sv */
// Package for the indexed list store: sizes, operation and status codes, the
// cell control struct shared by the top level and the cell chain, and the result
// metadata struct of the top level. No dependencies.
package ils_pkg;

	// list capacity and field widths
	localparam int CAPACITY  = 64;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int POS_W     = 7;
	localparam int CNT_OUT_W = 7;
	localparam int STAT_W    = 2;

	// internal widths derived from the capacity
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_A = (IDX_W > CNT_W) ? IDX_W : CNT_W;
	localparam int CMP_W = (CMP_A > POS_W) ? CMP_A : POS_W;

	// read-out OR tree: groups of eight cells
	localparam int GRP  = 8;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FN_INSERT = 2'd0;
	localparam func_t FN_REMOVE = 2'd1;
	localparam func_t FN_GET    = 2'd2;
	localparam func_t FN_SET    = 2'd3;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_INDEX = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              ins_en;
		logic              rem_en;
		logic              set_en;
		logic              rd_en;
		logic [CMP_W-1:0]  pos;
		logic [DATA_W-1:0] val;
	} cell_ctrl_t;

	// result fields that travel alongside the read-out pipeline
	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] count;
		logic                 keep;
	} meta_t;

endpackage

/* rtl/ils_req_if.sv */
// Request channel of the indexed list store: valid, ready and the request fields.
// Depends on ils_pkg.
interface ils_req_if;
	import ils_pkg::*;

	logic                     valid;
	logic                     ready;
	func_t                    func;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value_in;

	modport source (output valid, func, position, value_in, input ready);
	modport sink   (input valid, func, position, value_in, output ready);

endinterface

/* rtl/ils_rsp_if.sv */
// Result channel of the indexed list store: valid, ready and the result fields.
// Depends on ils_pkg.
interface ils_rsp_if;
	import ils_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value_out;
	logic [CNT_OUT_W-1:0]     count;
	status_t                  status;

	modport source (output valid, value_out, count, status, input ready);
	modport sink   (input valid, value_out, count, status, output ready);

endinterface

/* rtl/ils_cell.sv */
// One list cell: holds a single entry, shifts from either neighbour on insert
// or remove, and captures its entry for read-out when it is the target. Uses ils_pkg.
module ils_cell (
	input  logic                      clk,
	input  ils_pkg::cell_ctrl_t       ctrl,
	input  logic [ils_pkg::CMP_W-1:0] idx,
	input  logic [ils_pkg::DATA_W-1:0] prev_data,
	input  logic [ils_pkg::DATA_W-1:0] next_data,
	output logic [ils_pkg::DATA_W-1:0] data,
	output logic [ils_pkg::DATA_W-1:0] rd
);
	import ils_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] rd_s1;
	logic              hit;

	assign hit = (idx == ctrl.pos);

	// entry update: shift up above the insert point, shift down from the remove point
	always_ff @(posedge clk) begin
		priority if (ctrl.ins_en && (idx > ctrl.pos)) begin
			data_q <= prev_data;
		end else if ((ctrl.ins_en || ctrl.set_en) && hit) begin
			data_q <= ctrl.val;
		end else if (ctrl.rem_en && (idx >= ctrl.pos)) begin
			data_q <= next_data;
		end else begin
			data_q <= data_q;
		end
	end

	// read-out tap: old contents of the target cell, zero elsewhere
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_s1 <= hit ? data_q : '0;
		end
	end

	assign data = data_q;
	assign rd   = rd_s1;

endmodule

/* rtl/ils_chain.sv */
// Row of CAPACITY list cells, each wired to its two neighbours.
// Depends on ils_pkg and ils_cell.
module ils_chain (
	input  logic                       clk,
	input  ils_pkg::cell_ctrl_t        ctrl,
	output logic [ils_pkg::DATA_W-1:0] rd [ils_pkg::CAPACITY]
);
	import ils_pkg::*;

	logic [DATA_W-1:0] data [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] prev_d;
		logic [DATA_W-1:0] next_d;

		// ends of the row see zero from outside
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_p
			assign prev_d = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_n
			assign next_d = data[i+1];
		end

		ils_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (CMP_W'(i)),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (data[i]),
			.rd        (rd[i])
		);
	end

endmodule

/* rtl/indexed_list_store_core.sv */
// Top level of the indexed list store: request decode, entry count, read-out
// OR tree and result register. Depends on ils_pkg, ils_req_if, ils_rsp_if, ils_chain.
//
//  channel  modport  fields                      meaning
//  req      sink     func, position, value_in    insert/remove/get/set request
//  rsp      source   value_out, count, status    one result per request
//
// A request is checked and applied to the cell row at the edge that accepts it;
// the shift of every later entry happens in that one edge.
// Its result passes three registers in order: cell tap, group OR, result register.
// One request per cycle is taken while the result side keeps up; each stage
// holds under back-pressure and req.ready falls only when all three are full.
// Reset clears the entry count and the stage valid bits; entries are not reset.
module indexed_list_store_core (
	input  logic       clk,
	input  logic       arst_n,
	ils_req_if.sink    req,
	ils_rsp_if.source  rsp
);
	import ils_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	status_t           st;
	logic              ok;
	logic              acc;
	logic              ready1;
	logic              ready2;
	logic              ready3;
	cell_ctrl_t        ctrl;
	meta_t             meta_in;

	logic              v_s1;
	meta_t             meta_s1;
	logic              v_s2;
	meta_t             meta_s2;
	logic [DATA_W-1:0] grp_s2 [NGRP];
	logic [DATA_W-1:0] grp_or [NGRP];
	logic [DATA_W-1:0] rd     [CAPACITY];
	logic [DATA_W-1:0] all_or;

	logic              out_v_q;
	logic [DATA_W-1:0] out_val_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;
	status_t           out_st_q;

	// stall chain
	assign ready3    = !out_v_q || rsp.ready;
	assign ready2    = !v_s2 || ready3;
	assign ready1    = !v_s1 || ready2;
	assign req.ready = ready1;
	assign acc       = req.valid && ready1;

	// range and capacity check against the current count
	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(cnt_q);

	always_comb begin
		st = ST_OK;
		unique case (req.func)
			FN_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ST_BAD_INDEX;
				end else if (cnt_x == CMP_W'(CAPACITY)) begin
					st = ST_FULL;
				end
			end
			FN_REMOVE, FN_GET, FN_SET: begin
				if (pos_x >= cnt_x) begin
					st = ST_BAD_INDEX;
				end
			end
		endcase
	end

	assign ok = (st == ST_OK);

	// cell row control
	always_comb begin
		ctrl.ins_en = acc && ok && (req.func == FN_INSERT);
		ctrl.rem_en = acc && ok && (req.func == FN_REMOVE);
		ctrl.set_en = acc && ok && (req.func == FN_SET);
		ctrl.rd_en  = ready1;
		ctrl.pos    = pos_x;
		ctrl.val    = DATA_W'(req.value_in);
	end

	// next count
	always_comb begin
		priority if (ctrl.ins_en) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (ctrl.rem_en) begin
			cnt_nxt = cnt_q - 1'b1;
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	assign meta_in.status = st;
	assign meta_in.count  = CNT_OUT_W'(cnt_nxt);
	assign meta_in.keep   = ok && ((req.func == FN_REMOVE) || (req.func == FN_GET));

	ils_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.rd   (rd)
	);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ready1) begin
				v_s1 <= acc;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (ready3) begin
				out_v_q <= v_s2;
			end
		end
	end

	// group OR over eight cell taps each
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | rd[g * GRP + k];
				end
			end
		end
	end

	// final OR across the groups
	always_comb begin
		all_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			all_or = all_or | grp_s2[g];
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (ready1) begin
			meta_s1 <= meta_in;
		end
		if (ready2) begin
			meta_s2 <= meta_s1;
			grp_s2  <= grp_or;
		end
		if (ready3) begin
			out_val_q <= meta_s2.keep ? all_or : '0;
			out_cnt_q <= meta_s2.count;
			out_st_q  <= meta_s2.status;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.value_out = $signed(out_val_q);
	assign rsp.count     = out_cnt_q;
	assign rsp.status    = out_st_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("insert did not raise the entry count");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem_en |=> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
		else $error("remove did not lower the entry count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.value_out != '0)) |-> (rsp.status == ST_OK))
		else $error("data returned with an error status");

endmodule

/* tb/indexed_list_store_core_tb.sv */
// Testbench for indexed_list_store_core: drives insert/remove/get/set requests,
// predicts each result from a shadow copy of the list and checks it field by field.
// Depends on ils_pkg, ils_req_if, ils_rsp_if and the indexed_list_store_core RTL.
module indexed_list_store_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ils_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		func_t                    func;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value_in;
	} list_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [CNT_OUT_W-1:0]     count;
		status_t                  status;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	ils_req_if req_ch();
	ils_rsp_if rsp_ch();

	indexed_list_store_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_req_t pending_reqs[$];
	list_rsp_t expected_rsps[$];

	// shadow of the list contents, updated as requests are accepted
	logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
	int shadow_count = 0;

	// entry count as the stimulus sees it, used to aim positions
	int plan_count = 0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit long_hold     = 1'b0;
	int err_count     = 0;
	int quiet_cycles  = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// apply one request to the shadow list and return the result it gives
	function automatic list_rsp_t apply_list_op(input list_req_t r);
		list_rsp_t o;
		int p;
		o.value_out = '0;
		o.status    = ST_OK;
		p           = int'(r.position);
		if (r.func == FN_INSERT) begin
			if (p > shadow_count) begin
				o.status = ST_BAD_INDEX;
			end else if (shadow_count >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				for (int i = shadow_count; i > p; i--)
					shadow_entries[i] = shadow_entries[i-1];
				shadow_entries[p] = r.value_in;
				shadow_count++;
			end
		end else if (p >= shadow_count) begin
			o.status = ST_BAD_INDEX;
		end else begin
			case (r.func)
				FN_REMOVE: begin
					o.value_out = shadow_entries[p];
					for (int i = p; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
				FN_GET: begin
					o.value_out = shadow_entries[p];
				end
				default: begin
					shadow_entries[p] = r.value_in;
				end
			endcase
		end
		o.count = CNT_OUT_W'(shadow_count);
		return o;
	endfunction

	// queue one request, keeping the planned count in step
	task automatic push_req(input func_t f, input int pos, input logic signed [DATA_W-1:0] v);
		if (f == FN_INSERT && pos <= plan_count && plan_count < CAPACITY)
			plan_count++;
		else if (f == FN_REMOVE && pos < plan_count)
			plan_count--;
		pending_reqs.push_back('{f, POS_W'(pos), v});
	endtask

	// random requests; ins_w and rem_w weight the mix, get and set share the rest
	task automatic queue_random(input int n, input int ins_w, input int rem_w);
		func_t f;
		int pick;
		int pos;
		logic signed [DATA_W-1:0] v;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < ins_w)
				f = FN_INSERT;
			else if (pick < ins_w + rem_w)
				f = FN_REMOVE;
			else if (pick < ins_w + rem_w + (100 - ins_w - rem_w) / 2)
				f = FN_GET;
			else
				f = FN_SET;
			// mostly sensible positions, the rest anywhere in the field
			if ($urandom_range(0, 9) < 8) begin
				if (f == FN_INSERT)
					pos = $urandom_range(0, plan_count);
				else
					pos = (plan_count > 0) ? $urandom_range(0, plan_count - 1) : 0;
			end else begin
				pos = $urandom_range(0, (1 << POS_W) - 1);
			end
			case ($urandom_range(0, 15))
				0:       v = VAL_MIN;
				1:       v = VAL_MAX;
				2:       v = '0;
				3:       v = '1;
				default: v = $urandom;
			endcase
			push_req(f, pos, v);
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_req
		list_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(apply_list_op('{req_ch.func, req_ch.position,
					req_ch.value_in}));
			if (req_ch.valid && !req_ch.ready) begin
				// request still waiting: hold it
			end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.func     <= nxt.func;
				req_ch.position <= nxt.position;
				req_ch.value_in <= nxt.value_in;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and ready generation
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		list_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf("result with none expected: value %0d count %0d status %0d",
						rsp_ch.value_out, rsp_ch.count, rsp_ch.status));
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_ch.value_out !== exp_rsp.value_out)
						report_mismatch($sformatf("value_out got %0d expected %0d",
							rsp_ch.value_out, exp_rsp.value_out));
					if (rsp_ch.count !== exp_rsp.count)
						report_mismatch($sformatf("count got %0d expected %0d",
							rsp_ch.count, exp_rsp.count));
					if (rsp_ch.status !== exp_rsp.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							rsp_ch.status, exp_rsp.status));
				end
			end
			rsp_ch.ready <= !long_hold && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = FN_GET;
		req_ch.position = '0;
		req_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-list errors, bad insert positions, extremes, shifts
		push_req(FN_REMOVE, 0, 1);
		push_req(FN_GET, 0, 2);
		push_req(FN_SET, 0, 3);
		push_req(FN_INSERT, 1, 4);
		push_req(FN_INSERT, (1 << POS_W) - 1, 5);
		push_req(FN_INSERT, 0, VAL_MIN);
		push_req(FN_INSERT, 1, VAL_MAX);
		push_req(FN_INSERT, 0, 0);
		push_req(FN_INSERT, 1, -1);
		push_req(FN_INSERT, 5, 6);
		push_req(FN_GET, 0, 0);
		push_req(FN_GET, 3, 0);
		push_req(FN_GET, 4, 0);
		push_req(FN_SET, 2, 32'sh5555_5555);
		push_req(FN_GET, 2, 0);
		push_req(FN_SET, 3, 32'shaaaa_aaaa);
		push_req(FN_GET, 3, 0);
		push_req(FN_REMOVE, 1, 0);
		push_req(FN_REMOVE, 2, 0);
		push_req(FN_REMOVE, 0, 0);
		push_req(FN_REMOVE, 1, 0);
		push_req(FN_REMOVE, 0, 0);
		push_req(FN_GET, 0, 0);
		wait_drained();

		// receiver holds off while requests keep coming, so the pipeline backs up
		queue_random(40, 80, 7);
		long_hold = 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		long_hold = 1'b0;
		wait_drained();

		// four idling mixes, each filling the list past full, then a remove-heavy mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			queue_random(120, 80, 7);
			queue_random(70, 10, 50);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/ils_pkg.sv
rtl/ils_req_if.sv
rtl/ils_rsp_if.sv
rtl/ils_cell.sv
rtl/ils_chain.sv
rtl/indexed_list_store_core.sv
tb/indexed_list_store_core_tb.sv
